// ===== src/mqllm_pkg.sv =====
// Package with shared defaults and the sequencer state type of the linked-list queue manager.
`default_nettype none

package mqllm_pkg;

  localparam int unsigned NODE_COUNT_DEF  = 64;
  localparam int unsigned QUEUE_COUNT_DEF = 4;
  localparam int unsigned PID_WIDTH_DEF   = 16;

  typedef enum logic [4:0] {
    S_INIT  = 5'b00001,
    S_IDLE  = 5'b00010,
    S_FETCH = 5'b00100,
    S_LINK  = 5'b01000,
    S_DEQ   = 5'b10000
  } state_t;

endpackage

`default_nettype wire

// ===== src/multi_queue_linked_list_manager.sv =====
// Top level: several FIFO queues sharing one linked node pool with a FIFO free list.
// An accepted request passes S_FETCH and S_LINK, which registers the result of an enqueue or
// refused dequeue; a dequeue returning a pid adds S_DEQ, for the dependent node memory reads.
// A new transaction is accepted in the cycle its predecessor's result is shown.
// After reset the block sweeps the link memory, one node per cycle, with busy high; the
// receiver cannot stall, and each result is shown for exactly one cycle.
`default_nettype none

module multi_queue_linked_list_manager #(
  parameter int unsigned NODE_COUNT  = mqllm_pkg::NODE_COUNT_DEF,
  parameter int unsigned QUEUE_COUNT = mqllm_pkg::QUEUE_COUNT_DEF,
  parameter int unsigned PID_WIDTH   = mqllm_pkg::PID_WIDTH_DEF,
  localparam int unsigned QSW = (QUEUE_COUNT > 1) ? $clog2(QUEUE_COUNT) : 1,
  localparam int unsigned CW  = $clog2(NODE_COUNT + 1)
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  output logic                      busy,
  input  wire logic                 in_func,
  input  wire logic [QSW-1:0]       in_queue_sel,
  input  wire logic [PID_WIDTH-1:0] in_pid_in,
  output logic                      out_valid,
  output logic                      out_ok,
  output logic [PID_WIDTH-1:0]      out_pid_out,
  output logic                      out_queue_empty,
  output logic [CW-1:0]             out_free_count
);
  import mqllm_pkg::*;

  localparam int unsigned NW = $clog2(NODE_COUNT);
  localparam logic [NW-1:0] LAST_NODE = NW'(NODE_COUNT - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(NODE_COUNT);
  localparam logic [QSW:0] QCMP = (QSW + 1)'(QUEUE_COUNT);

  state_t state_r, state_nxt;

  logic [NW-1:0]        init_cnt_r, init_cnt_nxt;
  logic                 func_r;
  logic [QSW-1:0]       q_r;
  logic [PID_WIDTH-1:0] pid_r;
  logic [NW-1:0]        node_r, node_nxt;
  logic [NW-1:0]        free_head_r, free_head_nxt;
  logic [NW-1:0]        free_tail_r, free_tail_nxt;
  logic [CW-1:0]        free_cnt_r, free_cnt_nxt;
  logic [QUEUE_COUNT-1:0] nonempty_r, nonempty_nxt;

  logic [NW-1:0]        node_next_mem [NODE_COUNT];
  logic [PID_WIDTH-1:0] node_pid_mem  [NODE_COUNT];
  logic [NW-1:0]        qhead_mem     [QUEUE_COUNT];
  logic [NW-1:0]        qtail_mem     [QUEUE_COUNT];

  logic [NW-1:0]        nnext_rd_r;
  logic [PID_WIDTH-1:0] npid_rd_r;
  logic [NW-1:0]        qhead_rd_r;
  logic [NW-1:0]        qtail_rd_r;

  logic [NW-1:0]        nn_raddr;
  logic                 nn_we;
  logic [NW-1:0]        nn_waddr, nn_wdata;
  logic                 np_we;
  logic                 qh_we, qt_we;
  logic [NW-1:0]        qh_wdata, qt_wdata;

  logic                 out_valid_r, out_valid_nxt;
  logic                 out_ok_r, out_ok_nxt;
  logic [PID_WIDTH-1:0] out_pid_r, out_pid_nxt;
  logic                 out_empty_r, out_empty_nxt;
  logic [CW-1:0]        out_free_r, out_free_nxt;

  logic accept;
  logic in_range;
  logic q_nonempty;

  assign busy            = (state_r != S_IDLE);
  assign accept          = start && (state_r == S_IDLE);
  assign in_range        = ({1'b0, q_r} < QCMP);
  assign q_nonempty      = in_range && nonempty_r[q_r];
  assign out_valid       = out_valid_r;
  assign out_ok          = out_ok_r;
  assign out_pid_out     = out_pid_r;
  assign out_queue_empty = out_empty_r;
  assign out_free_count  = out_free_r;

  always_comb begin
    state_nxt     = state_r;
    init_cnt_nxt  = init_cnt_r;
    node_nxt      = node_r;
    free_head_nxt = free_head_r;
    free_tail_nxt = free_tail_r;
    free_cnt_nxt  = free_cnt_r;
    nonempty_nxt  = nonempty_r;
    nn_raddr      = free_head_r;
    nn_we         = 1'b0;
    nn_waddr      = init_cnt_r;
    nn_wdata      = (init_cnt_r == LAST_NODE) ? '0 : init_cnt_r + NW'(1);
    np_we         = 1'b0;
    qh_we         = 1'b0;
    qt_we         = 1'b0;
    qh_wdata      = free_head_r;
    qt_wdata      = free_head_r;
    out_valid_nxt = 1'b0;
    out_ok_nxt    = 1'b0;
    out_pid_nxt   = '0;
    out_empty_nxt = 1'b1;
    out_free_nxt  = free_cnt_r;
    unique case (state_r)
      S_INIT: begin
        nn_we        = 1'b1;
        init_cnt_nxt = init_cnt_r + NW'(1);
        if (init_cnt_r == LAST_NODE) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_FETCH;
        end
      end
      S_FETCH: begin
        state_nxt = S_LINK;
      end
      S_LINK: begin
        state_nxt     = S_IDLE;
        out_valid_nxt = 1'b1;
        out_empty_nxt = !q_nonempty;
        if (in_range && !func_r && (free_cnt_r != '0)) begin
          free_head_nxt = nnext_rd_r;
          free_cnt_nxt  = free_cnt_r - CW'(1);
          np_we         = 1'b1;
          if (nonempty_r[q_r]) begin
            nn_we    = 1'b1;
            nn_waddr = qtail_rd_r;
            nn_wdata = free_head_r;
          end else begin
            qh_we = 1'b1;
          end
          qt_we                 = 1'b1;
          nonempty_nxt[q_r]     = 1'b1;
          out_ok_nxt            = 1'b1;
          out_empty_nxt         = 1'b0;
          out_free_nxt          = free_cnt_r - CW'(1);
        end else if (func_r && q_nonempty) begin
          out_valid_nxt = 1'b0;
          nn_raddr      = qhead_rd_r;
          node_nxt      = qhead_rd_r;
          state_nxt     = S_DEQ;
        end
      end
      S_DEQ: begin
        state_nxt     = S_IDLE;
        out_valid_nxt = 1'b1;
        out_ok_nxt    = 1'b1;
        out_pid_nxt   = npid_rd_r;
        out_empty_nxt = (node_r == qtail_rd_r);
        if (node_r == qtail_rd_r) begin
          nonempty_nxt[q_r] = 1'b0;
        end else begin
          qh_we    = 1'b1;
          qh_wdata = nnext_rd_r;
        end
        if (free_cnt_r == '0) begin
          free_head_nxt = node_r;
        end else begin
          nn_we    = 1'b1;
          nn_waddr = free_tail_r;
          nn_wdata = node_r;
        end
        free_tail_nxt = node_r;
        free_cnt_nxt  = free_cnt_r + CW'(1);
        out_free_nxt  = free_cnt_r + CW'(1);
      end
      default: begin
        state_nxt = S_INIT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      init_cnt_r  <= '0;
      free_head_r <= '0;
      free_tail_r <= LAST_NODE;
      free_cnt_r  <= FULL_CNT;
      nonempty_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      init_cnt_r  <= init_cnt_nxt;
      free_head_r <= free_head_nxt;
      free_tail_r <= free_tail_nxt;
      free_cnt_r  <= free_cnt_nxt;
      nonempty_r  <= nonempty_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      func_r <= in_func;
      q_r    <= in_queue_sel;
      pid_r  <= in_pid_in;
    end
    node_r      <= node_nxt;
    out_ok_r    <= out_ok_nxt;
    out_pid_r   <= out_pid_nxt;
    out_empty_r <= out_empty_nxt;
    out_free_r  <= out_free_nxt;
  end

  always_ff @(posedge clk) begin
    if (nn_we) begin
      node_next_mem[nn_waddr] <= nn_wdata;
    end
    nnext_rd_r <= node_next_mem[nn_raddr];
  end

  always_ff @(posedge clk) begin
    if (np_we) begin
      node_pid_mem[free_head_r] <= pid_r;
    end
    npid_rd_r <= node_pid_mem[nn_raddr];
  end

  always_ff @(posedge clk) begin
    if (qh_we) begin
      qhead_mem[q_r] <= qh_wdata;
    end
    qhead_rd_r <= qhead_mem[q_r];
  end

  always_ff @(posedge clk) begin
    if (qt_we) begin
      qtail_mem[q_r] <= qt_wdata;
    end
    qtail_rd_r <= qtail_mem[q_r];
  end

endmodule

`default_nettype wire
